[sv/itrd_pkg.sv]
// itrd_pkg: shared types, constants and helper functions for the radix digit converter
// used by itrd_divider, itrd_digit_stack and integer_to_radix_digits_core
package itrd_pkg;

  localparam int unsigned RADIX_W = 5;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'd55;  // 'A' minus ten
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  // divider commands: load a fresh dividend or carry on with the quotient
  typedef struct packed {
    logic load;
    logic cont;
  } div_cmd_t;

  typedef struct packed {
    logic done;
    logic quot_zero;
  } div_stat_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DIGIT_TEN) res = CHAR_ZERO + CHAR_W'(d);
    else               res = CHAR_LETTER + CHAR_W'(d);
    return res;
  endfunction

endpackage

[sv/itrd_divider.sv]
// itrd_divider: bit-serial restoring divider by a small radix, one quotient bit per cycle
// depends on itrd_pkg
module itrd_divider #(
  parameter int unsigned VALUE_WIDTH = 31
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  itrd_pkg::div_cmd_t             cmd_i,
  input  logic [VALUE_WIDTH-1:0]         value_i,
  input  logic [itrd_pkg::RADIX_W-1:0]   radix_i,
  output itrd_pkg::div_stat_t            stat_o,
  output logic [itrd_pkg::DIGIT_W-1:0]   rem_o
);
  import itrd_pkg::*;

  localparam int unsigned CW = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] quot_q, quot_d;
  logic [DIGIT_W-1:0]     rem_q, rem_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   run_q, run_d;
  logic                   done_q, done_d;

  logic [RADIX_W-1:0] trial;
  logic [RADIX_W-1:0] diff;
  logic               ge;

  // partial remainder stays below the radix, so five bits hold the trial
  assign trial = {rem_q, quot_q[VALUE_WIDTH-1]};
  assign ge    = (trial >= radix_i);
  assign diff  = trial - radix_i;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (cmd_i.load || cmd_i.cont) begin
      if (cmd_i.load) quot_d = value_i;
      rem_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      quot_d = {quot_q[VALUE_WIDTH-2:0], ge};
      rem_d  = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CW'(VALUE_WIDTH - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign rem_o            = rem_q;
  assign stat_o.done      = done_q;
  assign stat_o.quot_zero = (quot_q == '0);

endmodule

[sv/itrd_digit_stack.sv]
// itrd_digit_stack: last-in first-out store of remainders, read back most significant first
// depends on itrd_pkg
module itrd_digit_stack #(
  parameter int unsigned VALUE_WIDTH = 31
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  itrd_pkg::stk_ctrl_t          ctrl_i,
  input  logic [itrd_pkg::DIGIT_W-1:0] digit_i,
  output logic                         last_pop_o,
  output logic [itrd_pkg::DIGIT_W-1:0] digit_o,
  output logic                         valid_o,
  output logic                         last_o
);
  import itrd_pkg::*;

  localparam int unsigned AW = $clog2(VALUE_WIDTH);
  localparam int unsigned PW = $clog2(VALUE_WIDTH + 1);

  logic [DIGIT_W-1:0] mem [VALUE_WIDTH];
  logic [PW-1:0]      sp_q, sp_d;
  logic [PW-1:0]      top_idx;
  logic [DIGIT_W-1:0] rdata_q;
  logic               valid_q, last_q;

  assign top_idx    = sp_q - 1'b1;
  assign last_pop_o = (sp_q == PW'(1));

  always_comb begin
    sp_d = sp_q;
    if (ctrl_i.push)     sp_d = sp_q + 1'b1;
    else if (ctrl_i.pop) sp_d = top_idx;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) mem[sp_q[AW-1:0]] <= digit_i;
    if (ctrl_i.pop)  rdata_q <= mem[top_idx[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q    <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      sp_q    <= sp_d;
      valid_q <= ctrl_i.pop;
      last_q  <= ctrl_i.pop && last_pop_o;
    end
  end

  assign digit_o = rdata_q;
  assign valid_o = valid_q;
  assign last_o  = last_q;

endmodule

[sv/integer_to_radix_digits_core.sv]
// integer_to_radix_digits_core: top level, radix register, sequencing and ascii output
// depends on itrd_pkg, itrd_divider and itrd_digit_stack
//
// Converts one unsigned integer per transaction into its digits in the radix held in the
// configuration register (2 to 16, writes clamped, reset value 10). Each digit comes out
// most significant first as an ascii character on digit_char_o for exactly one cycle with
// digit_valid_o high; last_digit_o marks the least significant digit, and zero gives a
// single '0'. The receiver cannot stall: every strobe is a delivered digit. Each digit is
// found by a bit-serial divider, and busy_o stays high through the strobe of the last
// digit. start_i is taken only while busy_o is low; a radix write is taken only
// while busy_o and start_i are both low.
module integer_to_radix_digits_core #(
  parameter int unsigned VALUE_WIDTH = 31
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [VALUE_WIDTH-1:0]       value_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [itrd_pkg::RADIX_W-1:0] cfg_data_i,
  output logic                         digit_valid_o,
  output logic [itrd_pkg::CHAR_W-1:0]  digit_char_o,
  output logic                         last_digit_o
);
  import itrd_pkg::*;

  state_e             state_q, state_d;
  logic [RADIX_W-1:0] radix_q;
  div_cmd_t           div_cmd;
  div_stat_t          div_stat;
  stk_ctrl_t          stk_ctrl;
  logic [DIGIT_W-1:0] rem;
  logic [DIGIT_W-1:0] out_digit;
  logic               last_pop;
  logic               out_valid, out_last;
  logic               accept;

  assign busy_o      = (state_q != S_IDLE) || out_valid;
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = !busy_o && !start_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radix_q <= clamp_radix(cfg_data_i);
    end
  end

  always_comb begin
    state_d       = state_q;
    div_cmd       = '0;
    stk_ctrl      = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          div_cmd.load = 1'b1;
          state_d      = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          stk_ctrl.push = 1'b1;
          if (div_stat.quot_zero) state_d = S_EMIT;
          else                    div_cmd.cont = 1'b1;
        end
      end
      S_EMIT: begin
        stk_ctrl.pop = 1'b1;
        if (last_pop) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  itrd_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .value_i(value_i),
    .radix_i(radix_q),
    .stat_o (div_stat),
    .rem_o  (rem)
  );

  itrd_digit_stack #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_digit_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (stk_ctrl),
    .digit_i   (rem),
    .last_pop_o(last_pop),
    .digit_o   (out_digit),
    .valid_o   (out_valid),
    .last_o    (out_last)
  );

  assign digit_valid_o = out_valid;
  assign last_digit_o  = out_last;
  assign digit_char_o  = glyph(out_digit);

  // digits only follow a cycle spent reading back the stack
  a_valid_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_valid_o |-> $past(state_q == S_EMIT))
    else $error("digit strobe without stack read-back");

  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == S_DIV))
    else $error("accepted transaction did not start division");

  a_last_has_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_digit_o |-> digit_valid_o)
    else $error("last digit flag without strobe");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIV))
    else $error("divider finished outside division state");

endmodule

[dv/integer_to_radix_digits_checker.sv]
// integer_to_radix_digits_checker: watches the command, configuration and digit channels,
// predicts the digit sequence of each conversion and compares it with what comes out
// depends on itrd_pkg for widths and radix limits
module integer_to_radix_digits_checker #(
  parameter int unsigned VALUE_WIDTH = 31
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             busy_i,
  input  logic [VALUE_WIDTH-1:0]           value_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [itrd_pkg::RADIX_W-1:0]     cfg_data_i,
  input  logic                             digit_valid_i,
  input  logic [itrd_pkg::CHAR_W-1:0]      digit_char_i,
  input  logic                             last_digit_i,
  output int                               mismatch_count_o,
  output int                               pending_o,
  output int                               digits_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import itrd_pkg::*;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO     = 7'd48;
  localparam logic [CHAR_W-1:0]  ASCII_UPPER_A  = 7'd65;
  localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 4'd10;
  localparam int                 REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_t;

  digit_t             expected_digits[$];
  logic [RADIX_W-1:0] radix_q;
  int                 mismatches = 0;
  int                 digits_seen = 0;

  // remainders come out least significant first, so queue them in reverse
  function automatic void queue_digits(input logic [VALUE_WIDTH-1:0] v,
                                       input logic [RADIX_W-1:0] r);
    logic [DIGIT_W-1:0]     rem[VALUE_WIDTH+1];
    logic [VALUE_WIDTH-1:0] rest;
    logic [VALUE_WIDTH-1:0] base;
    int                     n;
    digit_t                 d;
    rest = v;
    base = VALUE_WIDTH'(r);
    n    = 0;
    // zero still yields a single '0'
    do begin
      rem[n] = DIGIT_W'(rest % base);
      rest   = rest / base;
      n++;
    end while (rest != '0);
    for (int k = n - 1; k >= 0; k--) begin
      if (rem[k] < DECIMAL_DIGITS) d.ch = ASCII_ZERO + CHAR_W'(rem[k]);
      else d.ch = ASCII_UPPER_A + CHAR_W'(rem[k] - DECIMAL_DIGITS);
      d.last = (k == 0);
      expected_digits.push_back(d);
    end
  endfunction

  function automatic void flag_mismatch(input string what, input digit_t want);
    if (mismatches < REPORT_LIMIT) begin
      $display("[%0t] %s: expected char 0x%02h last %0b, got char 0x%02h last %0b",
               $time, what, want.ch, want.last, digit_char_i, last_digit_i);
    end
    mismatches++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    digit_t want;
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
      expected_digits.delete();
      pending_o <= 0;
    end else begin
      // retire the oldest expectation before adding any new conversion
      if (digit_valid_i) begin
        digits_seen++;
        if (expected_digits.size() == 0) begin
          flag_mismatch("digit with no conversion pending", '0);
        end else begin
          want = expected_digits.pop_front();
          if (digit_char_i !== want.ch || last_digit_i !== want.last) begin
            flag_mismatch("digit mismatch", want);
          end
        end
      end
      if (start_i && !busy_i) begin
        queue_digits(value_i, radix_q);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_data_i < RADIX_MIN) radix_q <= RADIX_MIN;
        else if (cfg_data_i > RADIX_MAX) radix_q <= RADIX_MAX;
        else radix_q <= cfg_data_i;
      end
      pending_o <= expected_digits.size();
    end
    mismatch_count_o <= mismatches;
    digits_o         <= digits_seen;
  end

endmodule

[dv/integer_to_radix_digits_core_test.sv]
// integer_to_radix_digits_core_test: stimulus and verdict for the radix digit converter
// depends on itrd_pkg, integer_to_radix_digits_core and integer_to_radix_digits_checker
module integer_to_radix_digits_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import itrd_pkg::*;

  localparam int unsigned VALUE_WIDTH = 31;
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          SETTLE      = VALUE_WIDTH + 4;
  localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = '1;

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic                   start       = 1'b0;
  logic                   busy;
  logic [VALUE_WIDTH-1:0] value_in    = '0;
  logic                   cfg_valid   = 1'b0;
  logic                   cfg_ready;
  logic [RADIX_W-1:0]     cfg_data    = '0;
  logic                   digit_valid;
  logic [CHAR_W-1:0]      digit_char;
  logic                   last_digit;

  int mismatches;
  int pending;
  int digits;
  int idle_pct     = 14;
  int items_sent   = 0;
  int radix_writes = 0;
  int cycle_count  = 0;

  integer_to_radix_digits_core #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_o       (busy),
    .value_i      (value_in),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .digit_valid_o(digit_valid),
    .digit_char_o (digit_char),
    .last_digit_o (last_digit)
  );

  integer_to_radix_digits_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_i          (busy),
    .value_i         (value_in),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .digit_valid_i   (digit_valid),
    .digit_char_i    (digit_char),
    .last_digit_i    (last_digit),
    .mismatch_count_o(mismatches),
    .pending_o       (pending),
    .digits_o        (digits)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // start stays high into the next transaction when no idle cycle falls between them
  task automatic send_value(input logic [VALUE_WIDTH-1:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    value_in <= v;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_radix(input logic [RADIX_W-1:0] d);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    radix_writes++;
  endtask

  function automatic logic [RADIX_W-1:0] pick_radix();
    if ($urandom_range(0, 4) == 0) return RADIX_W'($urandom_range(0, 31));
    return RADIX_W'($urandom_range(2, 16));
  endfunction

  // mix of tiny values, shortened values and full-width values
  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    logic [VALUE_WIDTH-1:0] raw;
    raw = VALUE_WIDTH'($urandom);
    case ($urandom_range(0, 3))
      0: begin
        return VALUE_WIDTH'($urandom_range(0, 40));
      end
      1: begin
        return raw >> $urandom_range(0, VALUE_WIDTH - 1);
      end
      default: begin
        return raw;
      end
    endcase
  endfunction

  task automatic random_phase(input int pct);
    idle_pct = pct;
    for (int g = 0; g < 4; g++) begin
      set_radix(pick_radix());
      for (int i = 0; i < 9; i++) send_value(pick_value());
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** integer_to_radix_digits_core: FAILED **");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset radix of ten
    send_value('0);
    send_value(VALUE_WIDTH'(1));
    send_value(VALUE_WIDTH'(9));
    send_value(VALUE_WIDTH'(10));
    send_value(VALUE_MAX);
    // write below range, clamps to binary: longest digit strings
    set_radix(RADIX_W'(0));
    send_value('0);
    send_value(VALUE_WIDTH'(1));
    send_value(VALUE_MAX);
    send_value(VALUE_WIDTH'(32'h2AAA_AAAA));
    send_value(VALUE_WIDTH'(32'h5555_5555));
    // write above range, clamps to hex
    set_radix(RADIX_W'(31));
    send_value(VALUE_MAX);
    send_value(VALUE_WIDTH'(15));
    send_value(VALUE_WIDTH'(16));
    send_value(VALUE_WIDTH'(32'h7EDC_BA98));
    set_radix(RADIX_W'(1));
    send_value(VALUE_WIDTH'(2));
    set_radix(RADIX_W'(17));
    send_value(VALUE_WIDTH'(255));
    set_radix(RADIX_W'(3));
    send_value(VALUE_MAX);
    send_value(VALUE_WIDTH'(2));
    set_radix(RADIX_W'(16));
    send_value(VALUE_WIDTH'(32'h00AB_CDEF));

    random_phase(14);
    random_phase(66);
    random_phase(0);
    drain();

    if (pending != 0) $display("%0d expected digits never arrived", pending);
    $display("%0d conversions over %0d radix writes, %0d digits checked, %0d mismatches",
             items_sent, radix_writes, digits, mismatches);
    $display("covered zero, full-width values and clamped radix writes at light, heavy "
             , "and no sender idling");
    if (mismatches == 0 && pending == 0) begin
      $display("** integer_to_radix_digits_core: PASSED **");
    end else begin
      $display("** integer_to_radix_digits_core: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
sv/itrd_pkg.sv
sv/itrd_divider.sv
sv/itrd_digit_stack.sv
sv/integer_to_radix_digits_core.sv
dv/integer_to_radix_digits_checker.sv
dv/integer_to_radix_digits_core_test.sv
